// File: hdl/ctcw_pkg.sv
// shared types and constants for the compact target chain work block
`default_nettype none

package ctcw_pkg;

  localparam int unsigned WORD_W    = 64;
  localparam int unsigned NUM_WORDS = 4;
  localparam int unsigned WORK_W    = WORD_W * NUM_WORDS;
  localparam int unsigned BITS_W    = 32;
  localparam int unsigned MANT_W    = 23;
  localparam int unsigned SIGN_POS  = 23;
  localparam int unsigned EXP_LSB   = 24;
  localparam int unsigned EXP_W     = 8;
  localparam int unsigned STEP_W    = 8;
  localparam int unsigned IDX_W     = 2;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_DIVIDE,
    ST_INC,
    ST_ACCUM,
    ST_EMIT,
    ST_ERR
  } state_t;

endpackage

`default_nettype wire

// File: hdl/compact_target_chain_work_core.sv
// cumulative chain work from compact difficulty words, one shared adder under a sequencer
//
// Each transfer on the input carries a 32-bit compact difficulty word and a flag that marks
// the first header of a chain. The word is expanded into a 256-bit target; a zero word, a set
// sign bit or a mantissa that reaches bit 256 gives one result with status 1, work_word 0 and
// last_word 1, and the stored work is left alone. Otherwise the proof 2^256 / (target + 1) is
// found by restoring division, one quotient bit per cycle, and added to the stored work (or
// replaces it on a first header); the 256-bit work then leaves as four 64-bit words, most
// significant first, last_word on the fourth. After the input transfer an item passes through
// the expand state, the division steps, the quotient increment and the accumulation, and then
// its output words leave one per transfer, each held until out_ready; an invalid word goes
// from expansion straight to its single error result. The single 257-bit add/subtract unit
// serves the target increment, every division step, the quotient increment and the
// accumulation in turn. in_ready is high only while the block is idle.
`default_nettype none

module compact_target_chain_work_core (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [ctcw_pkg::BITS_W-1:0]         compact_bits,
  input  wire logic                                first_in_chain,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic                                     status,
  output logic [ctcw_pkg::WORD_W-1:0]              work_word,
  output logic                                     last_word
);

  localparam int unsigned WW = ctcw_pkg::WORK_W;

  // control
  ctcw_pkg::state_t state, state_next;
  logic [ctcw_pkg::STEP_W-1:0] step;   // division steps left, minus one
  logic [ctcw_pkg::IDX_W-1:0]  idx;    // output word counter

  // payload
  logic [ctcw_pkg::BITS_W-1:0] cbits;
  logic                        first;
  logic [WW-1:0]               rem;    // partial remainder
  logic [WW-1:0]               quo;    // dividend shifting out, quotient shifting in
  logic [WW-1:0]               dvs;    // divisor, target + 1
  logic [WW-1:0]               work;   // cumulative work

  // decode of the latched compact word
  logic [ctcw_pkg::EXP_W-1:0]  expo;
  logic [ctcw_pkg::MANT_W-1:0] mant;
  logic [ctcw_pkg::MANT_W-1:0] mant_adj;
  logic [ctcw_pkg::EXP_W-1:0]  byte_sh;
  logic [4:0]                  msb;
  logic [10:0]                 top_bit;
  logic                        invalid;
  logic [WW-1:0]               target;

  // shared adder
  logic [WW:0]   add_a;
  logic [WW:0]   add_b;
  logic          add_cin;
  logic [WW+1:0] add_sum;
  logic          sub_ok;

  assign in_ready = (state == ctcw_pkg::ST_IDLE);

  // expansion of the compact word
  always_comb begin
    expo    = cbits[ctcw_pkg::EXP_LSB +: ctcw_pkg::EXP_W];
    mant    = cbits[ctcw_pkg::MANT_W-1:0];
    byte_sh = '0;
    case (expo)
      8'd0:    mant_adj = '0;
      8'd1:    mant_adj = mant >> 16;
      8'd2:    mant_adj = mant >> 8;
      8'd3:    mant_adj = mant;
      default: begin
        mant_adj = mant;
        byte_sh  = expo - 8'd3;
      end
    endcase
    // highest set mantissa bit
    msb = '0;
    for (int i = 0; i < int'(ctcw_pkg::MANT_W); i++) begin
      if (mant_adj[i]) msb = 5'(i);
    end
    top_bit = {6'd0, msb} + {byte_sh, 3'd0};
    invalid = (cbits == '0) || cbits[ctcw_pkg::SIGN_POS] ||
              ((mant_adj != '0) && (top_bit >= 11'(WW)));
    // only used when valid, where a nonzero mantissa keeps the byte shift below 32
    target  = {{(WW-ctcw_pkg::MANT_W){1'b0}}, mant_adj} << {byte_sh[4:0], 3'd0};
  end

  // one adder for every step: target + 1, trial subtract, quotient + 1, accumulation
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_cin = 1'b0;
    case (state)
      ctcw_pkg::ST_EXPAND: begin
        add_a   = {1'b0, target};
        add_cin = 1'b1;
      end
      ctcw_pkg::ST_DIVIDE: begin
        // shifted remainder minus divisor, carry out means no borrow
        add_a   = {rem, quo[WW-1]};
        add_b   = {1'b1, ~dvs};
        add_cin = 1'b1;
      end
      ctcw_pkg::ST_INC: begin
        add_a   = {1'b0, quo};
        add_cin = 1'b1;
      end
      ctcw_pkg::ST_ACCUM: begin
        add_a = {1'b0, quo};
        add_b = first ? '0 : {1'b0, work};
      end
      default: begin
        add_a = '0;
      end
    endcase
    add_sum = {1'b0, add_a} + {1'b0, add_b} + {{(WW+1){1'b0}}, add_cin};
    sub_ok  = add_sum[WW+1];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ctcw_pkg::ST_IDLE:   if (in_valid) state_next = ctcw_pkg::ST_EXPAND;
      ctcw_pkg::ST_EXPAND: state_next = invalid ? ctcw_pkg::ST_ERR : ctcw_pkg::ST_DIVIDE;
      ctcw_pkg::ST_DIVIDE: if (step == '0) state_next = ctcw_pkg::ST_INC;
      ctcw_pkg::ST_INC:    state_next = ctcw_pkg::ST_ACCUM;
      ctcw_pkg::ST_ACCUM:  state_next = ctcw_pkg::ST_EMIT;
      ctcw_pkg::ST_EMIT: begin
        if (out_ready && (idx == ctcw_pkg::IDX_W'(ctcw_pkg::NUM_WORDS - 1)))
          state_next = ctcw_pkg::ST_IDLE;
      end
      ctcw_pkg::ST_ERR:    if (out_ready) state_next = ctcw_pkg::ST_IDLE;
      default:             state_next = ctcw_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    out_valid = 1'b0;
    status    = ctcw_pkg::STATUS_OK;
    work_word = '0;
    last_word = 1'b0;
    case (state)
      ctcw_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        // word 3 first
        work_word = work[{~idx, 6'd0} +: ctcw_pkg::WORD_W];
        last_word = (idx == ctcw_pkg::IDX_W'(ctcw_pkg::NUM_WORDS - 1));
      end
      ctcw_pkg::ST_ERR: begin
        out_valid = 1'b1;
        status    = ctcw_pkg::STATUS_BAD;
        last_word = 1'b1;
      end
      default: begin
        out_valid = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ctcw_pkg::ST_IDLE;
      step  <= '0;
      idx   <= '0;
    end else begin
      state <= state_next;
      case (state)
        ctcw_pkg::ST_EXPAND: step <= '1;
        ctcw_pkg::ST_DIVIDE: step <= step - ctcw_pkg::STEP_W'(1);
        ctcw_pkg::ST_ACCUM:  idx  <= '0;
        ctcw_pkg::ST_EMIT:   if (out_ready) idx <= idx + ctcw_pkg::IDX_W'(1);
        default:             step <= step;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ctcw_pkg::ST_IDLE: begin
        if (in_valid) begin
          cbits <= compact_bits;
          first <= first_in_chain;
        end
      end
      ctcw_pkg::ST_EXPAND: begin
        // dividend is 2^256 - 1 - target
        quo <= ~target;
        dvs <= add_sum[WW-1:0];
        rem <= '0;
      end
      ctcw_pkg::ST_DIVIDE: begin
        rem <= sub_ok ? add_sum[WW-1:0] : add_a[WW-1:0];
        quo <= {quo[WW-2:0], sub_ok};
      end
      ctcw_pkg::ST_INC: begin
        quo <= add_sum[WW-1:0];
      end
      default: begin
        rem <= rem;
      end
    endcase
  end

  // cumulative work keeps its reset value until the first valid header
  always_ff @(posedge clk) begin
    if (rst) begin
      work <= '0;
    end else if (state == ctcw_pkg::ST_ACCUM) begin
      work <= add_sum[WW-1:0];
    end
  end

endmodule

`default_nettype wire

// File: hdl/ctcw_checker.sv
// port-level checks for the compact target chain work block, with its bind
`default_nettype none

module ctcw_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           in_ready,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic                           status,
  input wire logic [ctcw_pkg::WORD_W-1:0]    work_word,
  input wire logic                           last_word
);

  // a waiting result holds still
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(work_word) && $stable(status) &&
                                 $stable(last_word))
    else $error("result changed while stalled");

  // one item at a time: never ready while a result is pending
  a_serial: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input ready while result pending");

  // an error result is alone and carries a zero word
  a_err_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> last_word && (work_word == '0))
    else $error("malformed error result");

  // the words of one work value follow without a gap
  a_word_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_word |=> out_valid && !status)
    else $error("gap inside a work value");

  // after the final transfer the block is idle again
  a_back_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last_word |=> in_ready && !out_valid)
    else $error("not idle after final transfer");

endmodule

bind compact_target_chain_work_core ctcw_checker u_ctcw_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .status    (status),
  .work_word (work_word),
  .last_word (last_word)
);

`default_nettype wire
